// ----- sv/cmet_pkg.sv -----
// ----------------------------------------------------------------------------
// cmet_pkg
// Shared types, constants and helpers of the cubic multibrot escape-time
// engine: register map, controller states, datapath command/status words.
// ----------------------------------------------------------------------------
package cmet_pkg;

  // Q6.26 fixed point
  localparam int unsigned FRAC_BITS  = 26;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned ITER_W     = 16;
  localparam int unsigned PIX_W      = 11;
  localparam int unsigned PAL_W      = 7;
  // pixel minus half image size, image sides up to 8192
  localparam int unsigned PIX_OFF_W  = 14;
  localparam int unsigned PADDR_W    = 5;

  // |z|^2 escape bound: 4.0 in Q6.26
  localparam logic [DATA_W:0]      ESC_LIMIT = 33'h0_1000_0000;
  localparam logic [PAL_W-1:0]     PAL_MOD   = 7'd100;
  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  // register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_STEP_X   = 3'd0,
    REG_STEP_Y   = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [STEP_W-1:0]        step_x;
    logic [STEP_W-1:0]        step_y;
    logic signed [DATA_W-1:0] offset_x;
    logic signed [DATA_W-1:0] offset_y;
    logic [ITER_W-1:0]        max_iter;
  } cfg_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    MS_MAPX,
    MS_MAPY,
    MS_X_X2,
    MS_X_Y2,
    MS_X2_Y,
    MS_Y_Y2,
    MS_X_X,
    MS_Y_Y
  } mul_sel_e;

  // destination of the registered product
  typedef enum logic [3:0] {
    WB_NONE,
    WB_CX,
    WB_CY,
    WB_T1,
    WB_T2,
    WB_T3,
    WB_T4,
    WB_X2,
    WB_Y2
  } wb_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAPX,
    ST_MAPY,
    ST_WBCY,
    ST_CHECK,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_WB4,
    ST_UPD,
    ST_SQ1,
    ST_SQ2,
    ST_WBSQ,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic     load;     // capture pixel, clear orbit
    mul_sel_e mul_sel;
    wb_sel_e  wb_sel;
    logic     update;   // commit z' or flag fixed point
    logic     retire;   // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic fixed;        // z' == z
    logic cont;         // |z|^2 <= 4 and count < max_iter
    logic out_free;     // output register can take a word
  } dp_sts_t;

  // saturate to signed 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/cmet_regs.sv -----
// ----------------------------------------------------------------------------
// cmet_regs
// APB register file: pixel steps, pan offsets and iteration limit.
// ----------------------------------------------------------------------------
module cmet_regs
  import cmet_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_STEP_X:   cfg_d.step_x   = pwdata[STEP_W-1:0];
        REG_STEP_Y:   cfg_d.step_y   = pwdata[STEP_W-1:0];
        REG_OFFSET_X: cfg_d.offset_x = $signed(pwdata);
        REG_OFFSET_Y: cfg_d.offset_y = $signed(pwdata);
        REG_MAX_ITER: cfg_d.max_iter = pwdata[ITER_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_x   <= 31'd117038;
      cfg_q.step_y   <= 31'd124276;
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
      cfg_q.max_iter <= 16'd50;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_STEP_X:   prdata = {1'b0, cfg_q.step_x};
      REG_STEP_Y:   prdata = {1'b0, cfg_q.step_y};
      REG_OFFSET_X: prdata = cfg_q.offset_x;
      REG_OFFSET_Y: prdata = cfg_q.offset_y;
      REG_MAX_ITER: prdata = {{(DATA_W-ITER_W){1'b0}}, cfg_q.max_iter};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/cmet_dp.sv -----
// ----------------------------------------------------------------------------
// cmet_dp
// Datapath: one shared 32x32 multiplier with registered product, Q6.26
// writeback, orbit registers, iteration and palette counters, result register.
// ----------------------------------------------------------------------------
module cmet_dp
  import cmet_pkg::*;
#(
  parameter int IMG_WIDTH  = 1720,
  parameter int IMG_HEIGHT = 1080
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic [PIX_W-1:0]  pix_x_i,
  input  logic [PIX_W-1:0]  pix_y_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ITER_W-1:0] iter_count_o,
  output logic              inside_res_o,
  output logic [PAL_W-1:0]  palette_index_o
);

  localparam int HalfW = IMG_WIDTH / 2;
  localparam int HalfH = IMG_HEIGHT / 2;

  logic [PIX_W-1:0]         pix_x_q, pix_y_q;
  logic signed [PIX_OFF_W-1:0] off_x, off_y;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_shr, map_sum, nx_sum, ny_sum;
  logic signed [DATA_W-1:0] q_res, map_sat, map_off, map_res;
  logic signed [DATA_W-1:0] x_q, y_q, x2_q, y2_q, cx_q, cy_q;
  logic signed [DATA_W-1:0] t1_q, t2_q, t3_q, t4_q;
  logic signed [DATA_W-1:0] nx, ny;
  logic [DATA_W:0]          mag;
  logic [ITER_W-1:0]        count_q;
  logic [PAL_W-1:0]         pal_q;
  logic                     fixed, is_inside;
  logic                     out_valid_q;
  logic [ITER_W-1:0]        iter_res_q;
  logic                     inside_res_q;
  logic [PAL_W-1:0]         pal_res_q;

  // pixel offset from image center
  assign off_x = $signed({{(PIX_OFF_W-PIX_W){1'b0}}, pix_x_q}) - $signed(PIX_OFF_W'(HalfW));
  assign off_y = $signed({{(PIX_OFF_W-PIX_W){1'b0}}, pix_y_q}) - $signed(PIX_OFF_W'(HalfH));

  // multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MS_MAPX: begin
        mul_a = DATA_W'(off_x);
        mul_b = $signed({1'b0, cfg_i.step_x});
      end
      MS_MAPY: begin
        mul_a = DATA_W'(off_y);
        mul_b = $signed({1'b0, cfg_i.step_y});
      end
      MS_X_X2: begin mul_a = x_q;  mul_b = x2_q; end
      MS_X_Y2: begin mul_a = x_q;  mul_b = y2_q; end
      MS_X2_Y: begin mul_a = x2_q; mul_b = y_q;  end
      MS_Y_Y2: begin mul_a = y_q;  mul_b = y2_q; end
      MS_X_X:  begin mul_a = x_q;  mul_b = x_q;  end
      MS_Y_Y:  begin mul_a = y_q;  mul_b = y_q;  end
      default: begin mul_a = x_q;  mul_b = x_q;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Q6.26 product: floor shift, then saturate
  assign prod_shr = prod_q >>> FRAC_BITS;
  assign q_res    = sat32(prod_shr);

  // pixel mapping: integer product saturated, plus offset, saturated
  assign map_sat = sat32(prod_q);
  assign map_off = (cmd_i.wb_sel == WB_CY) ? cfg_i.offset_y : cfg_i.offset_x;
  assign map_sum = PROD_W'(map_sat) + PROD_W'(map_off);
  assign map_res = sat32(map_sum);

  // next orbit point
  assign nx_sum = PROD_W'(t1_q) - (PROD_W'(t2_q) <<< 1) - PROD_W'(t2_q) + PROD_W'(cx_q);
  assign ny_sum = (PROD_W'(t3_q) <<< 1) + PROD_W'(t3_q) - PROD_W'(t4_q) + PROD_W'(cy_q);
  assign nx     = sat32(nx_sum);
  assign ny     = sat32(ny_sum);
  assign fixed  = (nx == x_q) && (ny == y_q);

  // loop condition; squares are never negative
  assign mag = {1'b0, x2_q} + {1'b0, y2_q};

  assign sts_o.fixed    = fixed;
  assign sts_o.cont     = (mag <= ESC_LIMIT) && (count_q < cfg_i.max_iter);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // orbit and term registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_x_q <= pix_x_i;
      pix_y_q <= pix_y_i;
      x_q     <= '0;
      y_q     <= '0;
      x2_q    <= '0;
      y2_q    <= '0;
    end else begin
      if (cmd_i.update && !fixed) begin
        x_q <= nx;
        y_q <= ny;
      end
      case (cmd_i.wb_sel)
        WB_CX:   cx_q <= map_res;
        WB_CY:   cy_q <= map_res;
        WB_T1:   t1_q <= q_res;
        WB_T2:   t2_q <= q_res;
        WB_T3:   t3_q <= q_res;
        WB_T4:   t4_q <= q_res;
        WB_X2:   x2_q <= q_res;
        WB_Y2:   y2_q <= q_res;
        default: ;
      endcase
    end
  end

  // iteration count and count mod 100
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pal_q   <= '0;
    end else if (cmd_i.load) begin
      count_q <= '0;
      pal_q   <= '0;
    end else if (cmd_i.update) begin
      if (fixed) begin
        count_q <= cfg_i.max_iter;
        pal_q   <= '0;
      end else begin
        count_q <= count_q + 1'b1;
        pal_q   <= (pal_q == PAL_MOD - 1'b1) ? '0 : pal_q + 1'b1;
      end
    end
  end

  // result register
  assign is_inside = count_q >= cfg_i.max_iter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.retire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.retire) begin
      iter_res_q   <= count_q;
      inside_res_q <= is_inside;
      pal_res_q    <= is_inside ? '0 : pal_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign iter_count_o    = iter_res_q;
  assign inside_res_o    = inside_res_q;
  assign palette_index_o = pal_res_q;

  // palette counter stays in range
  a_pal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_q < PAL_MOD)
    else $error("palette counter out of range");

  // controller never overwrites a waiting result
  a_retire_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.retire |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten");

  // an iteration is only committed below the limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && !fixed) |-> (count_q < cfg_i.max_iter))
    else $error("iteration beyond max_iter");

endmodule

// ----- sv/cmet_ctrl.sv -----
// ----------------------------------------------------------------------------
// cmet_ctrl
// Sequencer: maps the pixel, then runs z = z^3 + c one iteration at a time
// through the shared multiplier until escape, limit or fixed point.
// ----------------------------------------------------------------------------
module cmet_ctrl
  import cmet_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.mul_sel = MS_X_X;
    cmd_o.wb_sel  = WB_NONE;
    cmd_o.update  = 1'b0;
    cmd_o.retire  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MAPX;
        end
      end
      ST_MAPX: begin
        cmd_o.mul_sel = MS_MAPX;
        state_d       = ST_MAPY;
      end
      ST_MAPY: begin
        cmd_o.mul_sel = MS_MAPY;
        cmd_o.wb_sel  = WB_CX;
        state_d       = ST_WBCY;
      end
      ST_WBCY: begin
        cmd_o.wb_sel = WB_CY;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.cont ? ST_M1 : ST_DONE;
      end
      // cubic terms x*x2, x*y2, x2*y, y*y2
      ST_M1: begin
        cmd_o.mul_sel = MS_X_X2;
        state_d       = ST_M2;
      end
      ST_M2: begin
        cmd_o.mul_sel = MS_X_Y2;
        cmd_o.wb_sel  = WB_T1;
        state_d       = ST_M3;
      end
      ST_M3: begin
        cmd_o.mul_sel = MS_X2_Y;
        cmd_o.wb_sel  = WB_T2;
        state_d       = ST_M4;
      end
      ST_M4: begin
        cmd_o.mul_sel = MS_Y_Y2;
        cmd_o.wb_sel  = WB_T3;
        state_d       = ST_WB4;
      end
      ST_WB4: begin
        cmd_o.wb_sel = WB_T4;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.fixed ? ST_DONE : ST_SQ1;
      end
      // new squares
      ST_SQ1: begin
        cmd_o.mul_sel = MS_X_X;
        state_d       = ST_SQ2;
      end
      ST_SQ2: begin
        cmd_o.mul_sel = MS_Y_Y;
        cmd_o.wb_sel  = WB_X2;
        state_d       = ST_WBSQ;
      end
      ST_WBSQ: begin
        cmd_o.wb_sel = WB_Y2;
        state_d      = ST_CHECK;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.retire = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/cubic_multibrot_escape_time_top.sv -----
// ----------------------------------------------------------------------------
// Sequence: load, map x and y, then per iteration a check, four cubic products,
//   the update and two squares; a fixed point ends at the update, skipping the squares.
// Throughput: one pixel at a time; next word can be taken the cycle after the
//   result is registered, while that result waits for out_ready_i.
// Each iteration runs six products through one shared multiplier.
// Reset: registers to defaults, no pixel held, output word invalid.
// ----------------------------------------------------------------------------
// cubic_multibrot_escape_time_top
// Escape-time engine for z = z^3 + c in Q6.26 with APB configuration.
// ----------------------------------------------------------------------------
module cubic_multibrot_escape_time_top
  import cmet_pkg::*;
#(
  parameter int IMG_WIDTH  = 1720,
  parameter int IMG_HEIGHT = 1080
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // pixel input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [PIX_W-1:0]   pix_x_i,
  input  logic [PIX_W-1:0]   pix_y_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ITER_W-1:0]  iter_count_o,
  output logic               inside_res_o,
  output logic [PAL_W-1:0]   palette_index_o
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  cmet_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cmet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cmet_dp #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .pix_x_i         (pix_x_i),
    .pix_y_i         (pix_y_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .iter_count_o    (iter_count_o),
    .inside_res_o    (inside_res_o),
    .palette_index_o (palette_index_o)
  );

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Cubic multibrot escape-time engine testbench
// Drives pixel words through the valid/ready input, programs the view over
// the APB port and checks every result word against a cycle-free predictor
// of the z = z^3 + c iteration in saturating Q6.26 arithmetic.
// ----------------------------------------------------------------------------
module testbench;
  import cmet_pkg::*;

  localparam int IMG_W = 1720;
  localparam int IMG_H = 1080;
  localparam int HALF_PERIOD = 4;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 125;

  // expected fields of one result word
  typedef struct {
    logic [ITER_W-1:0] count;
    logic              is_inside;
    logic [PAL_W-1:0]  pal;
  } pix_result_t;

  // view registers, pending results and the escape-time predictor
  class escape_scoreboard;
    longint      step_x;
    longint      step_y;
    longint      offset_x;
    longint      offset_y;
    int unsigned max_iter;
    pix_result_t pending_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned inside_seen;
    int unsigned deepest;

    function new();
      step_x   = 117038;
      step_y   = 124276;
      offset_x = 0;
      offset_y = 0;
      max_iter = 50;
      errors = 0;
      checked = 0;
      inside_seen = 0;
      deepest = 0;
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // Q6.26 product, floored, then saturated
    static function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return clamp32(p >>> FRAC_BITS);
    endfunction

    // unmapped addresses fall through and change nothing
    function void apply_write(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      case (addr[PADDR_W-1:2])
        REG_STEP_X:   step_x   = longint'(data[STEP_W-1:0]);
        REG_STEP_Y:   step_y   = longint'(data[STEP_W-1:0]);
        REG_OFFSET_X: offset_x = longint'(signed'(data));
        REG_OFFSET_Y: offset_y = longint'(signed'(data));
        REG_MAX_ITER: max_iter = int'(data[ITER_W-1:0]);
        default: ;
      endcase
    endfunction

    function pix_result_t escape_time(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      pix_result_t r;
      longint cx, cy, zx, zy, zx2, zy2, nx, ny;
      int unsigned n;
      cx = clamp32(clamp32((longint'(px) - IMG_W / 2) * step_x) + offset_x);
      cy = clamp32(clamp32((longint'(py) - IMG_H / 2) * step_y) + offset_y);
      zx = 0;
      zy = 0;
      zx2 = 0;
      zy2 = 0;
      n = 0;
      // iterate while |z|^2 <= 4.0
      while (zx2 + zy2 <= (64'sd1 << 28) && n < max_iter) begin
        nx = clamp32(qmul(zx, zx2) - 3 * qmul(zx, zy2) + cx);
        ny = clamp32(3 * qmul(zx2, zy) - qmul(zy, zy2) + cy);
        // orbit stuck on a fixed point: inside at once
        if (nx == zx && ny == zy) begin
          n = max_iter;
          break;
        end
        zx = nx;
        zy = ny;
        zx2 = qmul(zx, zx);
        zy2 = qmul(zy, zy);
        n++;
      end
      r.count     = n[ITER_W-1:0];
      r.is_inside = (n >= max_iter);
      r.pal       = r.is_inside ? '0 : PAL_W'(n % 100);
      return r;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      pending_q.push_back(escape_time(px, py));
    endfunction

    function void check_result(logic [ITER_W-1:0] cnt, logic ins, logic [PAL_W-1:0] pal);
      pix_result_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: result word with nothing pending: count %0d inside %0b pal %0d",
                 $time, cnt, ins, pal);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      if (exp_r.is_inside) begin
        inside_seen++;
      end else if (exp_r.count > deepest) begin
        deepest = exp_r.count;
      end
      if (cnt !== exp_r.count) begin
        $display("%0t: iter_count expected %0d actual %0d", $time, exp_r.count, cnt);
        errors++;
      end
      if (ins !== exp_r.is_inside) begin
        $display("%0t: inside_res expected %0b actual %0b", $time, exp_r.is_inside, ins);
        errors++;
      end
      if (pal !== exp_r.pal) begin
        $display("%0t: palette_index expected %0d actual %0d", $time, exp_r.pal, pal);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [PIX_W-1:0]   pix_x_i = '0;
  logic [PIX_W-1:0]   pix_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ITER_W-1:0]  iter_count_o;
  logic               inside_res_o;
  logic [PAL_W-1:0]   palette_index_o;

  // no idling on either side while set
  bit          calm = 1'b0;
  int unsigned settings = 0;

  escape_scoreboard sb = new();

  cubic_multibrot_escape_time_top #(
    .IMG_WIDTH  (IMG_W),
    .IMG_HEIGHT (IMG_H)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_ready_o,
    .pix_x_i,
    .pix_y_i,
    .out_valid_o,
    .out_ready_i,
    .iter_count_o,
    .inside_res_o,
    .palette_index_o
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(iter_count_o, inside_res_o, palette_index_o);
    end
    out_ready_i <= calm || ($urandom_range(99) >= 16);
  end

  // one APB write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.apply_write(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid and wait until every pending result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_view(input logic [DATA_W-1:0] sx, input logic [DATA_W-1:0] sy,
                              input logic [DATA_W-1:0] ox, input logic [DATA_W-1:0] oy,
                              input logic [DATA_W-1:0] mi);
    drain();
    cfg_write({REG_STEP_X, 2'b00}, sx);
    cfg_write({REG_STEP_Y, 2'b00}, sy);
    cfg_write({REG_OFFSET_X, 2'b00}, ox);
    cfg_write({REG_OFFSET_Y, 2'b00}, oy);
    cfg_write({REG_MAX_ITER, 2'b00}, mi);
    settings++;
  endtask

  // present one pixel word, optionally after a gap, and wait for acceptance
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pix_x_i    <= px;
    pix_y_i    <= py;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(px, py);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] sx, sy, ox, oy, mi;
    wait (rst_ni);
    @(posedge clk_i);

    // reset view: corners, center fixed point, pixel beyond the image
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd1719, 11'd1079);
    send_pixel(11'd860, 11'd540);
    send_pixel(11'd1719, 11'd0);
    send_pixel(11'd0, 11'd1079);
    send_pixel(11'd2047, 11'd2047);

    // zero iteration limit, written with junk in the upper bits
    drain();
    cfg_write({REG_MAX_ITER, 2'b00}, 32'hFFFF_0000);
    send_pixel(11'd860, 11'd540);
    send_pixel(11'd100, 11'd900);

    // widest steps and largest limit; unmapped writes must change nothing
    program_view(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0000_FFFF);
    for (int i = int'(REG_MAX_ITER) + 1; i < 8; i++) begin
      cfg_write(PADDR_W'(i * 4), 32'hFFFF_FFFF);
    end
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd860, 11'd540);
    send_pixel(11'd2047, 11'd2047);
    send_pixel(11'd860, 11'd0);
    send_pixel(11'd0, 11'd540);
    send_pixel(11'd2047, 11'd540);

    // smallest steps, offsets at both rails, limit of one
    program_view(32'h1, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
    send_pixel(11'd0, 11'd0);
    send_pixel(11'd1719, 11'd1079);
    send_pixel(11'd2047, 11'd2047);

    program_view(32'd117038, 32'd124276, 32'h7FFF_FFFF, 32'h8000_0000, 32'h3);
    send_pixel(11'd0, 11'd1079);
    send_pixel(11'd1719, 11'd0);

    // random views; one phase deep enough to wrap the palette, one calm phase
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      sx = ($urandom_range(3) != 0) ? 32'($urandom_range(2000, 400000)) : $urandom;
      sy = ($urandom_range(3) != 0) ? 32'($urandom_range(2000, 400000)) : $urandom;
      ox = ($urandom_range(3) != 0) ? 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27)
                                    : $urandom;
      oy = ($urandom_range(3) != 0) ? 32'($urandom_range(0, 1 << 28)) - 32'(1 << 27)
                                    : $urandom;
      mi = {16'($urandom),
            16'((ph == 5) ? $urandom_range(100, 130) : $urandom_range(1, 40))};
      program_view(sx, sy, ox, oy, mi);
      calm = (ph == 3);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(9) != 0) begin
          send_pixel(PIX_W'($urandom_range(0, IMG_W - 1)), PIX_W'($urandom_range(0, IMG_H - 1)));
        end else begin
          send_pixel(PIX_W'($urandom), PIX_W'($urandom));
        end
      end
    end
    calm = 1'b0;

    // let the last word settle and catch any stray result
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Covered %0d pixel words over %0d programmed views plus the reset view.",
             sb.checked, settings + 1);
    $display("Inside pixels: %0d, longest escape: %0d iterations.", sb.inside_seen, sb.deepest);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2 * HALF_PERIOD * 3_000_000);
    $display("Timeout waiting for the engine");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cmet_pkg.sv
sv/cmet_regs.sv
sv/cmet_dp.sv
sv/cmet_ctrl.sv
sv/cubic_multibrot_escape_time_top.sv
verif/testbench.sv
